// File: rtl/core/sm3_hash_engine_unit_macros.svh
// assertion macros for the sm3 hash engine
// no dependencies; included by the modules that assert
`ifndef SM3_HASH_ENGINE_UNIT_MACROS_SVH
`define SM3_HASH_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SM3_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SM3_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SM3_ASSERT(lbl, clk, rstn, prop, msg)
`define SM3_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/sm3_pkg.sv
// shared types, constants and functions of the sm3 hash engine
// no dependencies
package sm3_pkg;
  localparam logic [31:0] T_LO = 32'h79CC4519;
  localparam logic [31:0] T_HI = 32'h7A879D8A;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [255:0] IV = {32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
                                 32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F};

  typedef struct packed {
    logic start;
    logic busy;
  } cmp_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage

// File: rtl/core/sm3_hash_engine_unit.sv
// sm3 hash engine top level: byte packer, padding sequencer, digest output
// depends on sm3_pkg, sm3_compress and the assertion macros
// Takes one message word per beat. Each accepted word is placed into the block byte
// by byte (0..4 bytes) and then closed, with s_axis_tready low until the word is
// done. Each full 64-byte block then goes through the shared round
// unit (a start step plus 64 rounds, one per cycle), also with s_axis_tready
// low. A last word adds padding at one byte per cycle plus one or two
// compressions, then eight digest beats, one per cycle while m_axis_tready is
// high. No new word is accepted until the previous one has been fully processed.
`include "sm3_hash_engine_unit_macros.svh"
module sm3_hash_engine_unit import sm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_word[31:0], valid_bytes[34:32], zero fill
  input  logic        s_axis_tlast,  // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // digest_word[31:0], digest_index[34:32], zero fill
  output logic        m_axis_tlast   // digest_last
);
  typedef enum logic [2:0] {S_IDLE, S_BYTE, S_PAD, S_LEN, S_CMP, S_OUT} state_e;

  state_e       st_q;
  logic [511:0] blk_q;
  logic [255:0] cv_q;
  logic [5:0]   fill_q;
  logic [60:0]  tot_q;
  logic [31:0]  word_q;
  logic [2:0]   cnt_q;
  logic         last_q;
  logic [2:0]   k_q;
  logic [63:0]  bits_q;
  state_e       ret_q;
  logic [255:0] cv_new;
  logic         cmp_done;
  logic         start_q;
  cmp_ctl_t     ctl;
  logic [7:0]   nb;
  logic [2:0]   vb;

  assign vb = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
  assign s_axis_tready = (st_q == S_IDLE);
  assign ctl = '{start: start_q, busy: (st_q == S_CMP)};

  sm3_compress u_cmp (
    .clk_i, .rst_ni, .ctl_i(ctl), .block_i(blk_q), .chain_i(cv_q),
    .chain_o(cv_new), .done_o(cmp_done)
  );

  // byte to be placed this cycle
  always_comb begin
    unique case (st_q)
      S_BYTE:  nb = word_q[31:24];
      S_PAD:   nb = (k_q == 3'd0) ? PAD_BYTE : 8'h00;
      S_LEN:   nb = bits_q[63:56];
      default: nb = 8'h00;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cv_q <= IV; fill_q <= '0; tot_q <= '0; cnt_q <= '0;
      last_q <= 1'b0; k_q <= '0; ret_q <= S_IDLE; start_q <= 1'b0;
      m_axis_tvalid <= 1'b0; m_axis_tdata <= '0; m_axis_tlast <= 1'b0;
    end else begin
      start_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (s_axis_tvalid) begin
          word_q <= s_axis_tdata[31:0];
          cnt_q  <= vb;
          last_q <= s_axis_tlast;
          tot_q  <= tot_q + 61'(vb);
          k_q    <= '0;
          st_q   <= S_BYTE;
        end
        S_BYTE, S_PAD, S_LEN: begin
          if ((st_q == S_BYTE) && (cnt_q == 3'd0)) begin
            bits_q <= {tot_q, 3'b000};
            k_q    <= '0;
            st_q   <= last_q ? S_PAD : S_IDLE;
          end else begin
            blk_q[511 - 8*fill_q -: 8] <= nb;
            fill_q <= fill_q + 6'd1;
            if (st_q == S_BYTE) begin
              word_q <= {word_q[23:0], 8'h00};
              cnt_q  <= cnt_q - 3'd1;
            end else if (st_q == S_PAD) begin
              k_q <= 3'd1;
              if (fill_q + 6'd1 == LEN_POS) begin
                st_q <= S_LEN;
                k_q  <= '0;
              end
            end else begin
              bits_q <= {bits_q[55:0], 8'h00};
              k_q    <= k_q + 3'd1;
            end
            if (fill_q == 6'd63) begin
              start_q <= 1'b1;
              ret_q <= (st_q == S_LEN) ? S_OUT : st_q;
              st_q  <= S_CMP;
            end
          end
        end
        S_CMP: if (cmp_done) begin
          cv_q <= cv_new;
          if (ret_q == S_OUT) begin
            k_q <= '0;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {5'd0, 3'd0, cv_new[31:0]};
            m_axis_tlast  <= 1'b0;
          end
          st_q <= ret_q;
        end
        S_OUT: if (m_axis_tready) begin
          if (k_q == 3'd7) begin
            m_axis_tvalid <= 1'b0;
            cv_q <= IV; fill_q <= '0; tot_q <= '0;
            st_q <= S_IDLE;
          end else begin
            m_axis_tdata <= {5'd0, k_q + 3'd1, cv_q[32*(k_q+3'd1) +: 32]};
            m_axis_tlast <= (k_q == 3'd6);
            k_q <= k_q + 3'd1;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `SM3_ASSERT(a_out_state, clk_i, rst_ni, m_axis_tvalid |-> (st_q == S_OUT), "stray output")
  `SM3_ASSERT(a_idle_noout, clk_i, rst_ni, s_axis_tready |-> !m_axis_tvalid, "ready during output")
  `SM3_ASSERT(a_last_idx, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)), "tlast mismatch")
endmodule

// File: rtl/core/sm3_compress.sv
// sm3 compression: one round per cycle over a 16-word sliding expansion window
// depends on sm3_pkg and the assertion macros
`include "sm3_hash_engine_unit_macros.svh"
module sm3_compress import sm3_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmp_ctl_t       ctl_i,
  input  logic [511:0]   block_i,
  input  logic [255:0]   chain_i,
  output logic [255:0]   chain_o,
  output logic           done_o
);
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [5:0]  rnd_q;
  logic        run_q;
  logic [31:0] tj, a12, ss1, ss2, ffv, ggv, tt1, tt2, wn;

  // round datapath
  always_comb begin
    tj  = (rnd_q < 6'd16) ? T_LO : T_HI;
    a12 = rotl(v_q[0], 5'd12);
    ss1 = rotl(a12 + v_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    ffv = (rnd_q < 6'd16) ? (v_q[0] ^ v_q[1] ^ v_q[2])
        : ((v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]));
    ggv = (rnd_q < 6'd16) ? (v_q[4] ^ v_q[5] ^ v_q[6])
        : ((v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]));
    tt1 = ffv + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = ggv + v_q[7] + ss1 + w_q[0];
    wn  = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
    v_d[0] = tt1;  v_d[1] = v_q[0]; v_d[2] = rotl(v_q[1], 5'd9); v_d[3] = v_q[2];
    v_d[4] = p0(tt2); v_d[5] = v_q[4]; v_d[6] = rotl(v_q[5], 5'd19); v_d[7] = v_q[6];
  end

  // round counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
      run_q <= 1'b0;
    end else if (ctl_i.start) begin
      rnd_q <= '0;
      run_q <= 1'b1;
    end else if (run_q) begin
      rnd_q <= rnd_q + 6'd1;
      if (rnd_q == 6'd63) run_q <= 1'b0;
    end
  end

  // working variables and message window
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[511-32*i -: 32];
      for (int i = 0; i < 8; i++)  v_q[i] <= chain_i[32*i +: 32];
    end else if (run_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      for (int i = 0; i < 8; i++)  v_q[i] <= v_d[i];
    end
  end

  assign done_o = run_q && (rnd_q == 6'd63);
  always_comb begin
    for (int i = 0; i < 8; i++) chain_o[32*i +: 32] = chain_i[32*i +: 32] ^ v_d[i];
  end

  `SM3_ASSERT(a_start_idle, clk_i, rst_ni, ctl_i.start |-> !run_q, "start while running")
  `SM3_ASSERT(a_busy_run, clk_i, rst_ni, run_q |-> ctl_i.busy, "round without busy")
  `SM3_ASSERT(a_done_stop, clk_i, rst_ni, done_o |=> !run_q, "run past last round")
endmodule

// File: tb/tb.sv
// testbench for sm3_hash_engine_unit: hashes random and directed messages
// depends on sm3_pkg (iv and round constants) and the sm3_hash_engine_unit rtl
`timescale 1ns / 100ps
module tb import sm3_pkg::*; ();

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // data_word[31:0], valid_bytes[34:32], zero fill
  logic        s_axis_tlast = 1'b0; // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // digest_word[31:0], digest_index[34:32], zero fill
  logic        m_axis_tlast;       // digest_last

  sm3_hash_engine_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [31:0] chain_q [8];
  logic [31:0] blk_q [16];
  int unsigned fill_q;
  logic [60:0] bytes_q;
  digest_beat_t digest_fifo [$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;

  function automatic logic [31:0] rl(input logic [31:0] x, input int n);
    return (n % 32 == 0) ? x : ((x << (n % 32)) | (x >> (32 - n % 32)));
  endfunction

  task automatic sm3_compress();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ffv, ggv, tt1, tt2, x;
    for (int j = 0; j < 16; j++) w[j] = blk_q[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
      w[j] = x ^ rl(x, 15) ^ rl(x, 23) ^ rl(w[j-13], 7) ^ w[j-6];
    end
    {a, b, c, d} = {chain_q[0], chain_q[1], chain_q[2], chain_q[3]};
    {e, f, g, h} = {chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? T_LO : T_HI;
      a12 = rl(a, 12);
      ss1 = rl(a12 + e + rl(tj, j % 32), 7);
      ss2 = ss1 ^ a12;
      ffv = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
      ggv = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
      tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = ggv + h + ss1 + w[j];
      d = c; c = rl(b, 9); b = a; a = tt1;
      h = g; g = rl(f, 19); f = e;
      e = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
    end
    chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
    chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
  endtask

  task automatic append_byte(input logic [7:0] bv);
    blk_q[fill_q / 4][(3 - fill_q % 4) * 8 +: 8] = bv;
    fill_q = (fill_q + 1) % 64;
    if (fill_q == 0) sm3_compress();
  endtask

  task automatic hash_clear();
    for (int k = 0; k < 8; k++) chain_q[k] = IV[32*k +: 32];
    for (int k = 0; k < 16; k++) blk_q[k] = '0;
    fill_q = 0;
    bytes_q = '0;
  endtask

  // predicts the digest beats caused by one accepted input beat
  task automatic hash_word(input logic [31:0] word, input logic [2:0] cnt, input logic lst);
    int n;
    logic [63:0] bits;
    n = (cnt > 4) ? 4 : cnt;
    for (int k = 0; k < n; k++) append_byte(word[31 - 8*k -: 8]);
    bytes_q = bytes_q + 61'(n);
    if (lst) begin
      bits = {bytes_q, 3'b000};
      append_byte(PAD_BYTE);
      while (fill_q != LEN_POS) append_byte(8'h00);
      for (int k = 0; k < 8; k++) append_byte(bits[63 - 8*k -: 8]);
      for (int k = 0; k < 8; k++)
        digest_fifo.push_back('{word: chain_q[k], index: k[2:0], last: (k == 7)});
      hash_clear();
    end
  endtask

  // sends one beat and updates the prediction on acceptance
  task automatic send_word(input logic [31:0] word, input logic [2:0] cnt, input logic lst);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, cnt, word};
    s_axis_tlast <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    hash_word(word, cnt, lst);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int nwords);
    logic [2:0] tail;
    for (int k = 0; k < nwords - 1; k++) send_word($urandom, 3'd4, 1'b0);
    tail = 3'($urandom_range(4, 0));
    send_word($urandom, tail, 1'b1);
  endtask

  task automatic drain();
    int guard;
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (digest_fifo.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (200) @(negedge clk_i);
  endtask

  // receiver stall pattern, with a forced hold-off for the pressure test
  always @(negedge clk_i) begin
    if (hold_recv) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    digest_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{word: m_axis_tdata[31:0], index: m_axis_tdata[34:32], last: m_axis_tlast};
      if (digest_fifo.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest beat %h", got);
      end else begin
        want = digest_fifo.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch: expected word %h idx %0d last %b, got %h %0d %b",
                     want.word, want.index, want.last, got.word, got.index, got.last);
        end
      end
    end
  end

  task automatic test_directed();
    send_word(32'h0, 3'd0, 1'b1);                 // empty message
    send_word(32'h61626300, 3'd3, 1'b1);          // "abc"
    send_word(32'hFFFFFFFF, 3'd7, 1'b0);          // oversized count
    send_word(32'h12345678, 3'd0, 1'b0);          // zero bytes mid-message
    send_word(32'hABCDEF01, 3'd1, 1'b0);          // short word mid-message
    send_word(32'h00000000, 3'd5, 1'b0);
    send_word(32'hFFFFFFFF, 3'd6, 1'b1);
    for (int k = 0; k < 14; k++) send_word(32'hA5A5A5A5 ^ k, 3'd4, 1'b0);
    send_word(32'h5A5A5A5A, 3'd4, 1'b1);          // 60 bytes: extra pad block
    drain();
  endtask

  task automatic test_random(input int nwords, input int idle, input int stall);
    int sent, len;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < nwords) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(6, 1);
      if ($urandom_range(7, 0) == 0) begin
        send_word($urandom, 3'($urandom_range(7, 0)), 1'b0);
        sent++;
      end
      send_message(len);
      sent += len;
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        repeat (3) send_message(2);
      end
      begin
        repeat (3000) @(negedge clk_i);
        hold_recv = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    hash_clear();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(80, 0, 0);
    test_random(70, 88, 0);
    test_random(70, 0, 88);
    test_random(60, 8, 8);
    test_backpressure();
    if (errors == 0 && digest_fifo.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sm3_pkg.sv
rtl/core/sm3_compress.sv
rtl/core/sm3_hash_engine_unit.sv
tb/tb.sv
